[rtl/aab_pkg.sv]
// Package for the ARGB8888 alpha blend pixel unit.
// Holds the payload structs, stage structs, mode codes and the divide-by-255 helper.
// No dependencies.
`default_nettype none

package aab_pkg;

    localparam logic [1:0] MODE_COPY = 2'd0;
    localparam logic [1:0] MODE_BLIT = 2'd1;
    localparam logic [1:0] MODE_FILL = 2'd2;

    localparam logic [1:0] CFG_MODE         = 2'd0;
    localparam logic [1:0] CFG_GLOBAL_ALPHA = 2'd1;
    localparam logic [1:0] CFG_FILL_COLOR   = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    typedef enum logic [1:0] {
        OP_SKIP,
        OP_SRC,
        OP_BLEND
    } t_op;

    typedef struct packed {
        logic [31:0] src_pixel;
        logic [31:0] dst_pixel;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_pixel;
        logic        write_enable;
    } t_out_item;

    typedef struct packed {
        t_op         op;
        logic [7:0]  alpha;
        logic [23:0] color;
        logic [31:0] src;
        logic [31:0] dst;
    } t_s1;

    typedef struct packed {
        t_op         op;
        logic [7:0]  dst_a;
        logic [15:0] a_num;
        logic [15:0] r_sum;
        logic [15:0] g_sum;
        logic [15:0] b_sum;
        logic [31:0] src;
        logic [31:0] dst;
    } t_s2;

    // Floor of x / 255, exact for x up to 65279.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

[rtl/aab_decode.sv]
// First stage: resolves the mode into an operation and the effective alpha.
// Depends on aab_pkg.
`default_nettype none

module aab_decode
    import aab_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic       i_valid,
    input  wire t_in_item   i_data,
    input  wire logic [1:0] i_mode,
    input  wire logic [7:0] i_global_alpha,
    input  wire logic [31:0] i_fill_color,
    output logic            o_valid,
    output t_s1             o_data
);

    logic        r_valid;
    t_s1         r_data;
    t_s1         n_data;
    logic [15:0] ga_prod;
    logic [7:0]  src_a;
    logic [7:0]  eff_a;

    always_comb begin
        src_a   = i_data.src_pixel[31:24];
        ga_prod = {8'd0, src_a} * {8'd0, i_global_alpha};
        eff_a   = (i_global_alpha == ALPHA_OPAQUE) ? src_a : ga_prod[15:8];
        n_data.src   = i_data.src_pixel;
        n_data.dst   = i_data.dst_pixel;
        n_data.op    = OP_SKIP;
        n_data.alpha = eff_a;
        n_data.color = i_data.src_pixel[23:0];
        case (i_mode)
            MODE_COPY: begin
                n_data.op = OP_SRC;
            end
            MODE_BLIT: begin
                if (eff_a == ALPHA_OPAQUE) begin
                    n_data.op = OP_SRC;
                end else if (eff_a != ALPHA_CLEAR) begin
                    n_data.op = OP_BLEND;
                end
            end
            MODE_FILL: begin
                n_data.alpha = i_fill_color[31:24];
                n_data.color = i_fill_color[23:0];
                if (i_fill_color[31:24] != ALPHA_CLEAR) begin
                    n_data.op = OP_BLEND;
                end
            end
            default: begin
                n_data.op = OP_SKIP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

[rtl/aab_mul.sv]
// Second stage: forms the alpha and color products of the blend.
// Depends on aab_pkg.
`default_nettype none

module aab_mul
    import aab_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_s1  i_data,
    output logic      o_valid,
    output t_s2       o_data
);

    logic [7:0] inv_a;
    logic [7:0] inv_da;
    logic       r_valid;
    t_s2        r_data;
    t_s2        n_data;

    always_comb begin
        inv_a  = ALPHA_OPAQUE - i_data.alpha;
        inv_da = ALPHA_OPAQUE - i_data.dst[31:24];
        n_data.op    = i_data.op;
        n_data.src   = i_data.src;
        n_data.dst   = i_data.dst;
        n_data.dst_a = i_data.dst[31:24];
        n_data.a_num = {8'd0, inv_da} * {8'd0, i_data.alpha};
        n_data.r_sum = {8'd0, i_data.color[23:16]} * {8'd0, i_data.alpha}
                     + {8'd0, i_data.dst[23:16]} * {8'd0, inv_a};
        n_data.g_sum = {8'd0, i_data.color[15:8]} * {8'd0, i_data.alpha}
                     + {8'd0, i_data.dst[15:8]} * {8'd0, inv_a};
        n_data.b_sum = {8'd0, i_data.color[7:0]} * {8'd0, i_data.alpha}
                     + {8'd0, i_data.dst[7:0]} * {8'd0, inv_a};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

[rtl/aab_div.sv]
// Third stage: divides the products by 255 and selects the result item.
// Depends on aab_pkg.
`default_nettype none

module aab_div
    import aab_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_s2  i_data,
    output logic      o_valid,
    output t_out_item o_data
);

    logic      r_valid;
    t_out_item r_data;
    t_out_item n_data;
    logic [7:0] blend_a;

    always_comb begin
        blend_a = i_data.dst_a + div255(i_data.a_num);
        case (i_data.op)
            OP_SRC: begin
                n_data.out_pixel    = i_data.src;
                n_data.write_enable = 1'b1;
            end
            OP_BLEND: begin
                n_data.out_pixel    = {blend_a, div255(i_data.r_sum),
                                       div255(i_data.g_sum), div255(i_data.b_sum)};
                n_data.write_enable = 1'b1;
            end
            default: begin
                n_data.out_pixel    = i_data.dst;
                n_data.write_enable = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    a_skip_keeps_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_valid && i_data.op == OP_SKIP)
            |=> (r_data.out_pixel == $past(i_data.dst) && !r_data.write_enable))
        else $error("skipped item does not return the destination pixel");

    a_write_on_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_valid && i_data.op == OP_SRC)
            |=> (r_data.out_pixel == $past(i_data.src) && r_data.write_enable))
        else $error("copied item does not return the source pixel");

    a_hold_when_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> (r_valid == $past(r_valid)))
        else $error("output stage changed while held");

endmodule

`default_nettype wire

[rtl/argb_alpha_blend_pixel.sv]
// Top level of the ARGB8888 source-over alpha blend unit: config registers and stage control.
// Depends on aab_pkg, aab_decode, aab_mul and aab_div.
//
//   channel  | valid       | stall        | payload
//   ---------+-------------+--------------+----------------------------
//   input    | i_in_valid  | o_in_stall   | i_in_data  (t_in_item)
//   output   | o_out_valid | i_out_stall  | o_out_data (t_out_item)
//   config   | i_cfg_we    | none         | i_cfg_idx, i_cfg_data
//
// Each item passes three register stages: decode, multiply and divide.
// An accepted item moves from the decode register through the multiply register into the output register.
// One item is accepted every cycle while the output is not stalled.
// Reset clears all valid bits and loads mode copy, global alpha 255 and fill color 0.
// A stalled output holds its stage; earlier stages keep moving into empty slots.
`default_nettype none

module argb_alpha_blend_pixel
    import aab_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire t_in_item    i_in_data,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out_item        o_out_data,
    input  wire logic        i_out_stall,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    logic [1:0]  r_mode;
    logic [7:0]  r_global_alpha;
    logic [31:0] r_fill_color;

    logic s1_valid;
    logic s2_valid;
    t_s1  s1_data;
    t_s2  s2_data;
    logic en1;
    logic en2;
    logic en3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_COPY;
            r_global_alpha <= ALPHA_OPAQUE;
            r_fill_color   <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:         r_mode         <= i_cfg_data[1:0];
                CFG_GLOBAL_ALPHA: r_global_alpha <= i_cfg_data[7:0];
                CFG_FILL_COLOR:   r_fill_color   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign en3        = !o_out_valid || !i_out_stall;
    assign en2        = !s2_valid || en3;
    assign en1        = !s1_valid || en2;
    assign o_in_stall = !en1;

    aab_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en1),
        .i_valid        (i_in_valid),
        .i_data         (i_in_data),
        .i_mode         (r_mode),
        .i_global_alpha (r_global_alpha),
        .i_fill_color   (r_fill_color),
        .o_valid        (s1_valid),
        .o_data         (s1_data)
    );

    aab_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en2),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .o_data  (s2_data)
    );

    aab_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en3),
        .i_valid (s2_valid),
        .i_data  (s2_data),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !s1_valid && !s2_valid))
        else $error("pipeline not empty after reset");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> s1_valid)
        else $error("accepted item missing from first stage");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (s1_valid && s2_valid && o_out_valid))
        else $error("input stalled while pipeline has room");

endmodule

`default_nettype wire
